// ===== hw/rtl/tcse_pkg.sv =====
// tcse_pkg: types, codes and constants shared by the tcp connection state engine
// no dependencies; imported by tcp_connection_state_engine_core
`default_nettype none

package tcse_pkg;

  typedef enum logic [2:0] {
    OP_SYN  = 3'd0,
    OP_SEG  = 3'd1,
    OP_ACK  = 3'd2,
    OP_DATA = 3'd3,
    OP_FIN  = 3'd4,
    OP_TICK = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    PH_CLOSED      = 4'd0,
    PH_SYN_SENT    = 4'd1,
    PH_ESTABLISHED = 4'd2,
    PH_FIN_WAIT1   = 4'd3,
    PH_FIN_WAIT2   = 4'd4,
    PH_CLOSE_WAIT  = 4'd5,
    PH_LAST_ACK    = 4'd6,
    PH_TIME_WAIT   = 4'd7,
    PH_RESET       = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_HANDSHAKE = 3'd1,
    ST_RETX      = 3'd2,
    ST_REJECT    = 3'd3,
    ST_GAVE_UP   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    REG_LOCAL_PORT   = 3'd0,
    REG_REMOTE_PORT  = 3'd1,
    REG_INITIAL_SEQ  = 3'd2,
    REG_INITIAL_RTO  = 3'd3,
    REG_RETX_LIMIT   = 3'd4
  } cfg_reg_e;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 32;

  // tcp flag bits
  localparam logic [7:0] FLAG_FIN = 8'h01;
  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_RST = 8'h04;
  localparam logic [7:0] FLAG_PSH = 8'h08;
  localparam logic [7:0] FLAG_ACK = 8'h10;

  localparam logic [15:0] RTO_CAP            = 16'd16000;
  localparam logic [15:0] INITIAL_RTO_RESET  = 16'd1000;
  localparam logic [7:0]  RETX_LIMIT_RESET   = 8'd5;

  typedef struct packed {
    op_e         op;
    logic [15:0] seg_src_port;
    logic [15:0] seg_dst_port;
    logic [7:0]  seg_flags;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [15:0] seg_window;
    logic [15:0] data_len;
    logic [15:0] tx_window;
    logic [31:0] tick_ms;
  } in_t;

  typedef struct packed {
    status_e     status;
    phase_e      conn_state;
    logic        seg_out_valid;
    logic [7:0]  out_flags;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [15:0] out_window;
    logic [15:0] out_len;
    logic [15:0] peer_window;
  } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcp_connection_state_engine_core.sv =====
// tcp_connection_state_engine_core: one tcp connection, commands, segments and ticks
// depends on tcse_pkg
// a result appears in the cycle after its beat is accepted
// throughput: one beat per cycle; the connection registers update in the accept cycle
// an output register holds the result and input stall rises only while it is held
// reset (async, active low) loads the default config and a closed connection;
// a config write to a listed register re-initializes the connection state
`default_nettype none

module tcp_connection_state_engine_core
  import tcse_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_t                  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_t                      out_data_o
);

  // configuration
  logic [15:0] own_port_q, peer_port_q, rto_init_q;
  logic [31:0] iseq_q;
  logic [7:0]  retx_limit_q;
  logic        cfg_hit;
  logic [31:0] iseq_new;
  logic [15:0] rto_new;

  // connection state
  phase_e      phase_q, phase_d;
  logic [31:0] una_q, una_d, nxt_q, nxt_d, rcv_q, rcv_d;
  logic [15:0] pwin_q, pwin_d, rto_q, rto_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [7:0]  count_q, count_d;
  logic        pending_q, pending_d;
  logic [7:0]  sv_flags_q, sv_flags_d;
  logic [31:0] sv_seq_q, sv_seq_d, sv_ack_q, sv_ack_d;
  logic [15:0] sv_win_q, sv_win_d, sv_len_q, sv_len_d;

  // result register
  logic out_valid_q;
  out_t out_q, res;
  logic in_acc;

  // segment and tick decisions
  logic        port_ok, is_rst, ack_ok, synack, hs_ok, data_phase, fin_hit;
  logic [31:0] una_seg, rcv_data, rcv_fin, seq_end;
  logic        pend_seg;
  phase_e      phase_rx;
  logic [32:0] tick_sum;
  logic [31:0] el_sat;
  logic        expired, give_up;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // config write decode
  always_comb begin
    cfg_hit  = 1'b0;
    iseq_new = iseq_q;
    rto_new  = rto_init_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LOCAL_PORT, REG_REMOTE_PORT, REG_RETX_LIMIT: cfg_hit = 1'b1;
        REG_INITIAL_SEQ: begin
          cfg_hit  = 1'b1;
          iseq_new = cfg_wdata_i;
        end
        REG_INITIAL_RTO: begin
          cfg_hit = 1'b1;
          rto_new = cfg_wdata_i[15:0];
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // shared segment and tick checks
  always_comb begin
    port_ok    = (in_data_i.seg_src_port == peer_port_q) &&
                 (in_data_i.seg_dst_port == own_port_q);
    is_rst     = (in_data_i.seg_flags & FLAG_RST) != 8'd0;
    ack_ok     = ((in_data_i.seg_flags & FLAG_ACK) != 8'd0) &&
                 (in_data_i.seg_ack > una_q) && (in_data_i.seg_ack <= nxt_q);
    una_seg    = ack_ok ? in_data_i.seg_ack : una_q;
    pend_seg   = (ack_ok && (in_data_i.seg_ack == nxt_q)) ? 1'b0 : pending_q;
    synack     = (in_data_i.seg_flags & (FLAG_SYN | FLAG_ACK)) == (FLAG_SYN | FLAG_ACK);
    hs_ok      = in_data_i.seg_ack == nxt_q;
    data_phase = (phase_q == PH_ESTABLISHED) || (phase_q == PH_FIN_WAIT1) ||
                 (phase_q == PH_FIN_WAIT2);
    // in-order receive advance, then fin at the end of this segment
    rcv_data   = ((in_data_i.data_len != 16'd0) && (in_data_i.seg_seq == rcv_q)) ?
                 rcv_q + {16'd0, in_data_i.data_len} : rcv_q;
    seq_end    = in_data_i.seg_seq + {16'd0, in_data_i.data_len};
    fin_hit    = ((in_data_i.seg_flags & FLAG_FIN) != 8'd0) && (seq_end == rcv_data);
    rcv_fin    = fin_hit ? rcv_data + 32'd1 : rcv_data;
    phase_rx   = phase_q;
    if (fin_hit) begin
      phase_rx = (phase_q == PH_ESTABLISHED) ? PH_CLOSE_WAIT : PH_TIME_WAIT;
    end
    if ((phase_rx == PH_FIN_WAIT1) && (una_seg == nxt_q)) begin
      phase_rx = PH_FIN_WAIT2;
    end
    // saturating elapsed time
    tick_sum = {1'b0, elapsed_q} + {1'b0, in_data_i.tick_ms};
    el_sat   = tick_sum[32] ? '1 : tick_sum[31:0];
    expired  = el_sat >= {16'd0, rto_q};
    give_up  = count_q >= retx_limit_q;
  end

  // next connection state
  always_comb begin
    phase_d    = phase_q;
    una_d      = una_q;
    nxt_d      = nxt_q;
    rcv_d      = rcv_q;
    pwin_d     = pwin_q;
    rto_d      = rto_q;
    elapsed_d  = elapsed_q;
    count_d    = count_q;
    pending_d  = pending_q;
    sv_flags_d = sv_flags_q;
    sv_seq_d   = sv_seq_q;
    sv_ack_d   = sv_ack_q;
    sv_win_d   = sv_win_q;
    sv_len_d   = sv_len_q;
    unique case (in_data_i.op)
      OP_SYN: begin
        if (phase_q == PH_CLOSED) begin
          una_d      = nxt_q;
          nxt_d      = nxt_q + 32'd1;
          phase_d    = PH_SYN_SENT;
          sv_flags_d = FLAG_SYN;
          sv_seq_d   = nxt_q;
          sv_ack_d   = '0;
          sv_win_d   = in_data_i.tx_window;
          sv_len_d   = '0;
          pending_d  = 1'b1;
          elapsed_d  = '0;
        end
      end
      OP_SEG: begin
        if (port_ok) begin
          if (is_rst) begin
            phase_d   = PH_RESET;
            pending_d = 1'b0;
          end else begin
            una_d     = una_seg;
            pending_d = pend_seg;
            pwin_d    = in_data_i.seg_window;
            if (ack_ok) begin
              elapsed_d = '0;
              count_d   = '0;
            end
            if (phase_q == PH_SYN_SENT) begin
              if (synack && hs_ok) begin
                rcv_d     = in_data_i.seg_seq + 32'd1;
                phase_d   = PH_ESTABLISHED;
                pending_d = 1'b0;
                count_d   = '0;
              end
            end else if (data_phase) begin
              rcv_d   = rcv_fin;
              phase_d = phase_rx;
            end
          end
        end
      end
      OP_ACK: begin
      end
      OP_DATA: begin
        if ((phase_q == PH_ESTABLISHED) && (in_data_i.data_len != 16'd0)) begin
          una_d      = nxt_q;
          nxt_d      = nxt_q + {16'd0, in_data_i.data_len};
          sv_flags_d = FLAG_PSH | FLAG_ACK;
          sv_seq_d   = nxt_q;
          sv_ack_d   = rcv_q;
          sv_win_d   = in_data_i.tx_window;
          sv_len_d   = in_data_i.data_len;
          pending_d  = 1'b1;
          elapsed_d  = '0;
        end
      end
      OP_FIN: begin
        if ((phase_q == PH_ESTABLISHED) || (phase_q == PH_CLOSE_WAIT)) begin
          una_d      = nxt_q;
          nxt_d      = nxt_q + 32'd1;
          phase_d    = (phase_q == PH_CLOSE_WAIT) ? PH_LAST_ACK : PH_FIN_WAIT1;
          sv_flags_d = FLAG_FIN | FLAG_ACK;
          sv_seq_d   = nxt_q;
          sv_ack_d   = rcv_q;
          sv_win_d   = in_data_i.tx_window;
          sv_len_d   = '0;
          pending_d  = 1'b1;
          elapsed_d  = '0;
        end
      end
      OP_TICK: begin
        if (pending_q) begin
          elapsed_d = el_sat;
          if (expired) begin
            if (give_up) begin
              phase_d   = PH_RESET;
              pending_d = 1'b0;
            end else begin
              count_d   = count_q + 8'd1;
              elapsed_d = '0;
              if (rto_q < RTO_CAP) begin
                rto_d = {rto_q[14:0], 1'b0};
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result of the beat
  always_comb begin
    res             = '0;
    res.status      = ST_OK;
    res.conn_state  = phase_d;
    res.peer_window = pwin_d;
    unique case (in_data_i.op)
      OP_SYN: begin
        if (phase_q != PH_CLOSED) begin
          res.status = ST_REJECT;
        end else begin
          res.seg_out_valid = 1'b1;
          res.out_flags     = FLAG_SYN;
          res.out_seq       = nxt_q;
          res.out_window    = in_data_i.tx_window;
        end
      end
      OP_SEG: begin
        if (!port_ok) begin
          res.status = ST_REJECT;
        end else if (!is_rst && (phase_q == PH_SYN_SENT) && synack) begin
          res.status = hs_ok ? ST_HANDSHAKE : ST_REJECT;
        end
      end
      OP_ACK: begin
        res.seg_out_valid = 1'b1;
        res.out_flags     = FLAG_ACK;
        res.out_seq       = nxt_q;
        res.out_ack       = rcv_q;
        res.out_window    = in_data_i.tx_window;
      end
      OP_DATA: begin
        if ((phase_q != PH_ESTABLISHED) || (in_data_i.data_len == 16'd0)) begin
          res.status = ST_REJECT;
        end else begin
          res.seg_out_valid = 1'b1;
          res.out_flags     = FLAG_PSH | FLAG_ACK;
          res.out_seq       = nxt_q;
          res.out_ack       = rcv_q;
          res.out_window    = in_data_i.tx_window;
          res.out_len       = in_data_i.data_len;
        end
      end
      OP_FIN: begin
        if ((phase_q != PH_ESTABLISHED) && (phase_q != PH_CLOSE_WAIT)) begin
          res.status = ST_REJECT;
        end else begin
          res.seg_out_valid = 1'b1;
          res.out_flags     = FLAG_FIN | FLAG_ACK;
          res.out_seq       = nxt_q;
          res.out_ack       = rcv_q;
          res.out_window    = in_data_i.tx_window;
        end
      end
      OP_TICK: begin
        if (pending_q && expired) begin
          if (give_up) begin
            res.status = ST_GAVE_UP;
          end else begin
            res.status        = ST_RETX;
            res.seg_out_valid = 1'b1;
            res.out_flags     = sv_flags_q;
            res.out_seq       = sv_seq_q;
            res.out_ack       = sv_ack_q;
            res.out_window    = sv_win_q;
            res.out_len       = sv_len_q;
          end
        end
      end
      default: begin
        res.status = ST_REJECT;
      end
    endcase
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_port_q    <= '0;
      peer_port_q   <= '0;
      iseq_q        <= '0;
      rto_init_q    <= INITIAL_RTO_RESET;
      retx_limit_q  <= RETX_LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LOCAL_PORT:  own_port_q    <= cfg_wdata_i[15:0];
        REG_REMOTE_PORT: peer_port_q   <= cfg_wdata_i[15:0];
        REG_INITIAL_SEQ: iseq_q        <= cfg_wdata_i;
        REG_INITIAL_RTO: rto_init_q    <= cfg_wdata_i[15:0];
        REG_RETX_LIMIT:  retx_limit_q  <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // connection state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_CLOSED;
      una_q      <= '0;
      nxt_q      <= '0;
      rcv_q      <= '0;
      pwin_q     <= '0;
      rto_q      <= INITIAL_RTO_RESET;
      elapsed_q  <= '0;
      count_q    <= '0;
      pending_q  <= 1'b0;
      sv_flags_q <= '0;
      sv_seq_q   <= '0;
      sv_ack_q   <= '0;
      sv_win_q   <= '0;
      sv_len_q   <= '0;
    end else if (cfg_hit) begin
      phase_q    <= PH_CLOSED;
      una_q      <= iseq_new;
      nxt_q      <= iseq_new;
      rcv_q      <= '0;
      pwin_q     <= '0;
      rto_q      <= rto_new;
      elapsed_q  <= '0;
      count_q    <= '0;
      pending_q  <= 1'b0;
      sv_flags_q <= '0;
      sv_seq_q   <= '0;
      sv_ack_q   <= '0;
      sv_win_q   <= '0;
      sv_len_q   <= '0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      una_q      <= una_d;
      nxt_q      <= nxt_d;
      rcv_q      <= rcv_d;
      pwin_q     <= pwin_d;
      rto_q      <= rto_d;
      elapsed_q  <= elapsed_d;
      count_q    <= count_d;
      pending_q  <= pending_d;
      sv_flags_q <= sv_flags_d;
      sv_seq_q   <= sv_seq_d;
      sv_ack_q   <= sv_ack_d;
      sv_win_q   <= sv_win_d;
      sv_len_q   <= sv_len_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= res;
    end
  end

  // a held beat with no segment carries an all-zero header
  a_no_seg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.seg_out_valid) |->
      (out_q.out_flags == 8'd0 && out_q.out_seq == 32'd0 && out_q.out_ack == 32'd0 &&
       out_q.out_window == 16'd0 && out_q.out_len == 16'd0))
    else $error("header fields set without an outgoing segment");

  // giving up always lands in the reset phase
  a_gave_up_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_GAVE_UP) |-> (out_q.conn_state == PH_RESET))
    else $error("gave up without entering reset phase");

  // a built segment comes only with ok or retransmit status
  a_seg_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.seg_out_valid) |->
      (out_q.status == ST_OK || out_q.status == ST_RETX))
    else $error("segment emitted with reject or handshake status");

  // a closed connection never has a retransmission pending
  a_closed_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CLOSED) |-> !pending_q)
    else $error("retransmission pending while closed");

endmodule

`default_nettype wire
